>>> rtl/tbcp_pkg.sv
// Package for the tile box collision push block: shared types, codes and helpers.
// Used by every module of the block but the RAM; depends on nothing else.
package tbcp_pkg;

    // Fixed-point working width for overlaps and pushes (covers every FRAC_BITS setting).
    localparam int OVL_W = 20;
    localparam int SUM_W = OVL_W + 1;
    localparam int CORNERS = 4;

    typedef logic signed [OVL_W-1:0] t_ovl;
    typedef logic signed [SUM_W-1:0] t_sum;

    // Configuration register indexes.
    localparam logic [0:0] CFG_MAP_WIDTH  = 1'b0;
    localparam logic [0:0] CFG_MAP_HEIGHT = 1'b1;

    // Input operation codes.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Corner bits of the blocking mask.
    localparam logic [3:0] M_X1Y1 = 4'b0001;
    localparam logic [3:0] M_X2Y1 = 4'b0010;
    localparam logic [3:0] M_X1Y2 = 4'b0100;
    localparam logic [3:0] M_X2Y2 = 4'b1000;

    // One accepted request as held in the first pipeline stage.
    typedef struct packed {
        logic               op;
        logic [5:0]         tile_col;
        logic [5:0]         tile_row;
        logic [7:0]         tile_code;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [11:0]        half_w;
        logic [11:0]        half_h;
    } t_item;

    // Query state carried alongside the tile reads.
    typedef struct packed {
        logic [3:0] oor;
        logic       x_par;
        logic       y_par;
        logic [7:0] code;
        t_ovl       left;
        t_ovl       right;
        t_ovl       bottom;
        t_ovl       top;
    } t_qry;

    // Saturate a working value to a 16-bit signed result.
    function automatic logic signed [15:0] sat16(input t_ovl v);
        logic signed [15:0] r;
        if (v > t_ovl'(32767)) begin
            r = 16'sh7FFF;
        end else if (v < -t_ovl'(32768)) begin
            r = -16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/tbcp_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Stand-alone; uses no package.
module tbcp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data held while the enable is low.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/tbcp_front.sv
// Front stage: cell rounding, overlaps, bounds checks and bank addresses for one request.
// Depends on tbcp_pkg.
module tbcp_front #(
    parameter int MAX_COLS  = 64,
    parameter int MAX_ROWS  = 64,
    parameter int FRAC_BITS = 8,
    parameter int AW        = 10
) (
    input  tbcp_pkg::t_item i_item,
    input  logic [6:0]      i_w_eff,
    input  logic [6:0]      i_h_eff,
    output tbcp_pkg::t_qry  o_qry,
    output logic [AW-1:0]   o_addr [4],
    output logic [3:0]      o_wr_bank
);

    localparam int HALF_COLS = (MAX_COLS + 1) / 2;
    localparam int CW = 18 - FRAC_BITS;
    localparam logic signed [17:0] ONE18  = 18'sd1 <<< FRAC_BITS;
    localparam logic signed [17:0] HALF18 = 18'sd1 <<< (FRAC_BITS - 1);
    localparam tbcp_pkg::t_ovl ONE_FX  = tbcp_pkg::t_ovl'(1) <<< FRAC_BITS;
    localparam tbcp_pkg::t_ovl HALF_FX = tbcp_pkg::t_ovl'(1) <<< (FRAC_BITS - 1);

    logic signed [17:0] px18, py18, tx, ty;
    logic signed [CW-1:0] cx [2];
    logic signed [CW-1:0] cy [2];
    tbcp_pkg::t_ovl x1f, y1f, pxe, pye, hwe, hhe, we_e, he_e, lv, rv, bv, tv;
    tbcp_pkg::t_ovl ccx, ccy;
    logic signed [CW-1:0] colsel, rowsel;
    logic [AW-1:0] waddr;
    logic col_ok, row_ok;
    logic [3:0] oor;

    // Round the box centre minus one half to a cell, halves away from zero.
    always_comb begin
        px18 = 18'(i_item.pos_x);
        py18 = 18'(i_item.pos_y);
        tx = ONE18 - px18;
        ty = ONE18 - py18;
        cx[0] = (px18 < HALF18) ? CW'(-(tx >>> FRAC_BITS)) : CW'(px18 >>> FRAC_BITS);
        cy[0] = (py18 < HALF18) ? CW'(-(ty >>> FRAC_BITS)) : CW'(py18 >>> FRAC_BITS);
        cx[1] = cx[0] + CW'(1);
        cy[1] = cy[0] + CW'(1);
    end

    // Overlaps of the box with the cell centres, clamped at zero.
    always_comb begin
        x1f = tbcp_pkg::t_ovl'(cx[0]) <<< FRAC_BITS;
        y1f = tbcp_pkg::t_ovl'(cy[0]) <<< FRAC_BITS;
        pxe = tbcp_pkg::t_ovl'(i_item.pos_x);
        pye = tbcp_pkg::t_ovl'(i_item.pos_y);
        hwe = tbcp_pkg::t_ovl'(i_item.half_w);
        hhe = tbcp_pkg::t_ovl'(i_item.half_h);
        lv = x1f + HALF_FX - pxe + hwe;
        rv = pxe + hwe - x1f - ONE_FX + HALF_FX;
        bv = y1f + HALF_FX - pye + hhe;
        tv = pye + hhe - y1f - ONE_FX + HALF_FX;
        o_qry.oor    = oor;
        o_qry.left   = (lv < 0) ? '0 : lv;
        o_qry.right  = (rv < 0) ? '0 : rv;
        o_qry.bottom = (bv < 0) ? '0 : bv;
        o_qry.top    = (tv < 0) ? '0 : tv;
        o_qry.code   = i_item.tile_code;
        o_qry.x_par  = cx[0][0];
        o_qry.y_par  = cy[0][0];
    end

    // A corner outside the map in use counts as blocking.
    always_comb begin
        we_e = tbcp_pkg::t_ovl'(i_w_eff);
        he_e = tbcp_pkg::t_ovl'(i_h_eff);
        for (int k = 0; k < tbcp_pkg::CORNERS; k++) begin
            ccx = tbcp_pkg::t_ovl'(cx[k % 2]);
            ccy = tbcp_pkg::t_ovl'(cy[k / 2]);
            oor[k] = (ccx < 0) || (ccy < 0) || (ccx >= we_e) || (ccy >= he_e);
        end
    end

    // Write address and bank select; the parity of column and row picks the bank.
    always_comb begin
        col_ok = (int'(i_item.tile_col) < MAX_COLS);
        row_ok = (int'(i_item.tile_row) < MAX_ROWS);
        waddr = AW'((int'(i_item.tile_row) >> 1) * HALF_COLS + (int'(i_item.tile_col) >> 1));
        for (int b = 0; b < tbcp_pkg::CORNERS; b++) begin
            o_wr_bank[b] = (i_item.op == tbcp_pkg::OP_WRITE) && col_ok && row_ok &&
                           (i_item.tile_col[0] == b[0]) && (i_item.tile_row[0] == b[1]);
        end
    end

    // Query address per bank: the corner column and row whose parity match the bank.
    always_comb begin
        for (int b = 0; b < tbcp_pkg::CORNERS; b++) begin
            colsel = (cx[0][0] == b[0]) ? cx[0] : cx[1];
            rowsel = (cy[0][0] == b[1]) ? cy[0] : cy[1];
            if (i_item.op == tbcp_pkg::OP_QUERY) begin
                o_addr[b] = AW'(int'(tbcp_pkg::t_ovl'(rowsel) >>> 1) * HALF_COLS
                                + int'(tbcp_pkg::t_ovl'(colsel) >>> 1));
            end else begin
                o_addr[b] = waddr;
            end
        end
    end

endmodule

>>> rtl/tbcp_resolve.sv
// Resolve stage: blocking mask from the four tile reads and the push-out selection.
// Depends on tbcp_pkg.
module tbcp_resolve (
    input  tbcp_pkg::t_qry     i_qry,
    input  logic [7:0]         i_rdata [4],
    output logic signed [15:0] o_push_x,
    output logic signed [15:0] o_push_y,
    output logic [3:0]         o_mask
);

    logic [1:0] bank;
    tbcp_pkg::t_ovl rx, ry;
    tbcp_pkg::t_sum s_a, s_b;
    tbcp_pkg::t_ovl l, r, bt, tp;

    // Map each corner to the bank holding it and compare with the queried code.
    always_comb begin
        for (int k = 0; k < tbcp_pkg::CORNERS; k++) begin
            bank = {i_qry.y_par ^ k[1], i_qry.x_par ^ k[0]};
            o_mask[k] = i_qry.oor[k] || (i_rdata[bank] == i_qry.code);
        end
    end

    // Push-out vector chosen by the blocking pattern.
    always_comb begin
        l  = i_qry.left;
        r  = i_qry.right;
        bt = i_qry.bottom;
        tp = i_qry.top;
        rx = '0;
        ry = '0;
        s_a = '0;
        s_b = '0;
        case (o_mask)
            tbcp_pkg::M_X1Y1: begin
                if (l < bt) rx = l; else ry = bt;
            end
            tbcp_pkg::M_X2Y1: begin
                if (r < bt) rx = -r; else ry = bt;
            end
            tbcp_pkg::M_X1Y2: begin
                if (l < tp) rx = l; else ry = -tp;
            end
            tbcp_pkg::M_X2Y2: begin
                if (r < tp) rx = -r; else ry = -tp;
            end
            tbcp_pkg::M_X1Y1 | tbcp_pkg::M_X2Y1 | tbcp_pkg::M_X1Y2: begin
                rx = l;
                ry = bt;
            end
            tbcp_pkg::M_X1Y1 | tbcp_pkg::M_X2Y1 | tbcp_pkg::M_X2Y2: begin
                rx = -r;
                ry = bt;
            end
            tbcp_pkg::M_X1Y1 | tbcp_pkg::M_X1Y2 | tbcp_pkg::M_X2Y2: begin
                rx = l;
                ry = -tp;
            end
            tbcp_pkg::M_X2Y1 | tbcp_pkg::M_X1Y2 | tbcp_pkg::M_X2Y2: begin
                rx = -r;
                ry = -tp;
            end
            tbcp_pkg::M_X1Y1 | tbcp_pkg::M_X2Y1: ry = bt;
            tbcp_pkg::M_X1Y2 | tbcp_pkg::M_X2Y2: ry = -tp;
            tbcp_pkg::M_X1Y1 | tbcp_pkg::M_X1Y2: rx = l;
            tbcp_pkg::M_X2Y1 | tbcp_pkg::M_X2Y2: rx = -r;
            // Diagonal pair falling to the right: take the cheaper escape.
            tbcp_pkg::M_X2Y1 | tbcp_pkg::M_X1Y2: begin
                s_a = tbcp_pkg::t_sum'(l) + tbcp_pkg::t_sum'(bt);
                s_b = tbcp_pkg::t_sum'(r) + tbcp_pkg::t_sum'(tp);
                if (s_a < s_b) begin
                    rx = l;
                    ry = bt;
                end else begin
                    rx = -r;
                    ry = -tp;
                end
            end
            // Diagonal pair rising to the right.
            tbcp_pkg::M_X1Y1 | tbcp_pkg::M_X2Y2: begin
                s_a = tbcp_pkg::t_sum'(l) + tbcp_pkg::t_sum'(tp);
                s_b = tbcp_pkg::t_sum'(r) + tbcp_pkg::t_sum'(bt);
                if (s_a < s_b) begin
                    rx = l;
                    ry = -tp;
                end else begin
                    rx = -r;
                    ry = bt;
                end
            end
            default: begin
                rx = '0;
                ry = '0;
            end
        endcase
        o_push_x = tbcp_pkg::sat16(rx);
        o_push_y = tbcp_pkg::sat16(ry);
    end

endmodule

>>> rtl/tile_box_collision_push.sv
// Tile map store with a box push-out query, kept in four parity banks of synchronous RAM.
// A query passes the request register, then the tile reads with the query state register,
// then the output register before its result is presented; writes give no result.
// One request per cycle unless a held result stalls the pipeline; each query reads its
// four corners, one from each bank. An output stall holds the whole three-stage pipeline,
// so input stall follows it. Reset clears the pipeline valids and sets both map sizes to
// 64; tile contents are undefined until written and get no clearing pass.
module tile_box_collision_push #(
    parameter int MAX_COLS  = 64,
    parameter int MAX_ROWS  = 64,
    parameter int FRAC_BITS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_op,
    input  logic [5:0]         i_tile_col,
    input  logic [5:0]         i_tile_row,
    input  logic [7:0]         i_tile_code,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    input  logic [11:0]        i_half_w,
    input  logic [11:0]        i_half_h,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [15:0] o_push_x,
    output logic signed [15:0] o_push_y,
    output logic [3:0]         o_blocked_mask,
    input  logic               i_cfg_we,
    input  logic [0:0]         i_cfg_idx,
    input  logic [6:0]         i_cfg_data
);

    localparam int BANK_DEPTH = ((MAX_COLS + 1) / 2) * ((MAX_ROWS + 1) / 2);
    localparam int AW = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

    logic               adv;
    logic               r_v1, r_v2, r_v3;
    tbcp_pkg::t_item    r_s1;
    tbcp_pkg::t_qry     qry, r_qry;
    logic [AW-1:0]      addr [4];
    logic [3:0]         wr_bank, bank_we;
    logic [7:0]         rdata [4];
    logic [6:0]         r_map_width, r_map_height;
    logic [6:0]         w_eff, h_eff;
    logic signed [15:0] push_x, push_y;
    logic [3:0]         mask;
    logic signed [15:0] r_push_x, r_push_y;
    logic [3:0]         r_mask;

    // The pipeline moves unless a finished result is held by the consumer.
    assign adv        = !(r_v3 && i_out_stall);
    assign o_in_stall = !adv;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width  <= 7'd64;
            r_map_height <= 7'd64;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tbcp_pkg::CFG_MAP_WIDTH:  r_map_width  <= i_cfg_data;
                tbcp_pkg::CFG_MAP_HEIGHT: r_map_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Map size in use never exceeds the store.
    assign w_eff = (int'(r_map_width) > MAX_COLS) ? 7'(MAX_COLS) : r_map_width;
    assign h_eff = (int'(r_map_height) > MAX_ROWS) ? 7'(MAX_ROWS) : r_map_height;

    // Pipeline valids.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_in_valid;
            r_v2 <= r_v1 && (r_s1.op == tbcp_pkg::OP_QUERY);
            r_v3 <= r_v2;
        end
    end

    // Stage one: capture the request.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1.op        <= i_op;
            r_s1.tile_col  <= i_tile_col;
            r_s1.tile_row  <= i_tile_row;
            r_s1.tile_code <= i_tile_code;
            r_s1.pos_x     <= i_pos_x;
            r_s1.pos_y     <= i_pos_y;
            r_s1.half_w    <= i_half_w;
            r_s1.half_h    <= i_half_h;
        end
    end

    tbcp_front #(
        .MAX_COLS  (MAX_COLS),
        .MAX_ROWS  (MAX_ROWS),
        .FRAC_BITS (FRAC_BITS),
        .AW        (AW)
    ) u_front (
        .i_item    (r_s1),
        .i_w_eff   (w_eff),
        .i_h_eff   (h_eff),
        .o_qry     (qry),
        .o_addr    (addr),
        .o_wr_bank (wr_bank)
    );

    // Four parity banks; a write lands before any later query reads.
    assign bank_we = (r_v1 && adv) ? wr_bank : 4'b0000;

    for (genvar b = 0; b < tbcp_pkg::CORNERS; b++) begin : g_bank
        tbcp_ram #(
            .WIDTH (8),
            .DEPTH (BANK_DEPTH),
            .AW    (AW)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (bank_we[b]),
            .i_waddr (addr[b]),
            .i_wdata (r_s1.tile_code),
            .i_re    (adv),
            .i_raddr (addr[b]),
            .o_rdata (rdata[b])
        );
    end

    // Stage two: query state alongside the tile reads.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_qry <= qry;
        end
    end

    tbcp_resolve u_resolve (
        .i_qry    (r_qry),
        .i_rdata  (rdata),
        .o_push_x (push_x),
        .o_push_y (push_y),
        .o_mask   (mask)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_push_x <= push_x;
            r_push_y <= push_y;
            r_mask   <= mask;
        end
    end

    assign o_out_valid    = r_v3;
    assign o_push_x       = r_push_x;
    assign o_push_y       = r_push_y;
    assign o_blocked_mask = r_mask;

    // At most one bank takes a write in a cycle.
    a_we_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(bank_we))
        else $error("more than one tile bank written at once");

    // Only a write request in stage one writes the store.
    a_we_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (bank_we != 4'b0000) |-> (r_v1 && (r_s1.op == tbcp_pkg::OP_WRITE)))
        else $error("tile store written without a write request");

    // A query in stage one moves on to the read stage.
    a_qry_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && (r_s1.op == tbcp_pkg::OP_QUERY) && adv) |=> r_v2)
        else $error("query lost between stage one and stage two");

    // A query in the read stage reaches the output register.
    a_res_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && adv) |=> r_v3)
        else $error("query result lost before the output");

endmodule

>>> tb/sv/tile_push_checker.sv
// Checker for the tile box collision push block: it watches the request and result channels,
// predicts each push-out result and compares it field by field.
// Depends on tbcp_pkg for the request type, the operation codes and the mask bits.
module tile_push_checker #(
    parameter int MAX_COLS  = 64,
    parameter int MAX_ROWS  = 64,
    parameter int FRAC_BITS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic               i_op,
    input  logic [5:0]         i_tile_col,
    input  logic [5:0]         i_tile_row,
    input  logic [7:0]         i_tile_code,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    input  logic [11:0]        i_half_w,
    input  logic [11:0]        i_half_h,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic signed [15:0] i_push_x,
    input  logic signed [15:0] i_push_y,
    input  logic [3:0]         i_blocked_mask,
    input  logic               i_cfg_we,
    input  logic [0:0]         i_cfg_idx,
    input  logic [6:0]         i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending
);

    localparam int ONE_FX  = 1 << FRAC_BITS;
    localparam int HALF_FX = 1 << (FRAC_BITS - 1);

    typedef struct packed {
        logic signed [15:0] push_x;
        logic signed [15:0] push_y;
        logic [3:0]         mask;
    } t_push;

    // Shadow copy of the tile map and of both size registers.
    logic [7:0] tile_mem [MAX_COLS*MAX_ROWS];
    logic [6:0] width_cfg  = 7'd64;
    logic [6:0] height_cfg = 7'd64;

    t_push           pushes_due [$];
    t_push           due_push;
    t_push           seen_push;
    tbcp_pkg::t_item seen_req;
    int              fail_count = 0;

    // Cell index: position minus one half, rounded with halves away from zero.
    function automatic int cell_of(input int p);
        int v;
        v = p - HALF_FX;
        if (v >= 0) begin
            return (v + HALF_FX) >>> FRAC_BITS;
        end
        return -((-v + HALF_FX) >>> FRAC_BITS);
    endfunction

    function automatic int floor0(input int v);
        return (v < 0) ? 0 : v;
    endfunction

    function automatic logic signed [15:0] clip16(input int v);
        if (v > 32767) begin
            return 16'sh7FFF;
        end
        if (v < -32768) begin
            return 16'sh8000;
        end
        return 16'(v);
    endfunction

    // A corner blocks when it falls outside the map in use or holds the queried code.
    function automatic bit corner_blocks(input int cx, input int cy, input logic [7:0] code);
        int cols;
        int rows;
        cols = (width_cfg > MAX_COLS) ? MAX_COLS : int'(width_cfg);
        rows = (height_cfg > MAX_ROWS) ? MAX_ROWS : int'(height_cfg);
        if (cx < 0 || cy < 0 || cx >= cols || cy >= rows) begin
            return 1'b1;
        end
        return tile_mem[cy*MAX_COLS + cx] == code;
    endfunction

    // Push-out vector of one box query against the current map.
    function automatic t_push predict_push(input tbcp_pkg::t_item req);
        int px, py, hw, hh, x1, y1, x2, y2;
        int ov_left, ov_right, ov_bottom, ov_top, rx, ry;
        logic [3:0] mask;
        t_push res;
        px = req.pos_x;
        py = req.pos_y;
        hw = int'(req.half_w);
        hh = int'(req.half_h);
        x1 = cell_of(px);
        y1 = cell_of(py);
        x2 = x1 + 1;
        y2 = y1 + 1;
        ov_left   = floor0(x1*ONE_FX + HALF_FX - (px - hw));
        ov_right  = floor0(px + hw - (x2*ONE_FX - HALF_FX));
        ov_bottom = floor0(y1*ONE_FX + HALF_FX - (py - hh));
        ov_top    = floor0(py + hh - (y2*ONE_FX - HALF_FX));

        mask = 4'b0000;
        if (corner_blocks(x1, y1, req.tile_code)) mask |= tbcp_pkg::M_X1Y1;
        if (corner_blocks(x2, y1, req.tile_code)) mask |= tbcp_pkg::M_X2Y1;
        if (corner_blocks(x1, y2, req.tile_code)) mask |= tbcp_pkg::M_X1Y2;
        if (corner_blocks(x2, y2, req.tile_code)) mask |= tbcp_pkg::M_X2Y2;

        // Ties between two candidate pushes go to the second one.
        rx = 0;
        ry = 0;
        case (mask)
            tbcp_pkg::M_X1Y1: begin
                if (ov_left < ov_bottom) rx = ov_left; else ry = ov_bottom;
            end
            tbcp_pkg::M_X2Y1: begin
                if (ov_right < ov_bottom) rx = -ov_right; else ry = ov_bottom;
            end
            tbcp_pkg::M_X1Y2: begin
                if (ov_left < ov_top) rx = ov_left; else ry = -ov_top;
            end
            tbcp_pkg::M_X2Y2: begin
                if (ov_right < ov_top) rx = -ov_right; else ry = -ov_top;
            end
            tbcp_pkg::M_X1Y1 | tbcp_pkg::M_X2Y1 | tbcp_pkg::M_X1Y2: begin
                rx = ov_left;
                ry = ov_bottom;
            end
            tbcp_pkg::M_X1Y1 | tbcp_pkg::M_X2Y1 | tbcp_pkg::M_X2Y2: begin
                rx = -ov_right;
                ry = ov_bottom;
            end
            tbcp_pkg::M_X1Y1 | tbcp_pkg::M_X1Y2 | tbcp_pkg::M_X2Y2: begin
                rx = ov_left;
                ry = -ov_top;
            end
            tbcp_pkg::M_X2Y1 | tbcp_pkg::M_X1Y2 | tbcp_pkg::M_X2Y2: begin
                rx = -ov_right;
                ry = -ov_top;
            end
            tbcp_pkg::M_X1Y1 | tbcp_pkg::M_X2Y1: ry = ov_bottom;
            tbcp_pkg::M_X1Y2 | tbcp_pkg::M_X2Y2: ry = -ov_top;
            tbcp_pkg::M_X1Y1 | tbcp_pkg::M_X1Y2: rx = ov_left;
            tbcp_pkg::M_X2Y1 | tbcp_pkg::M_X2Y2: rx = -ov_right;
            tbcp_pkg::M_X2Y1 | tbcp_pkg::M_X1Y2: begin
                if (ov_left + ov_bottom < ov_right + ov_top) begin
                    rx = ov_left;
                    ry = ov_bottom;
                end else begin
                    rx = -ov_right;
                    ry = -ov_top;
                end
            end
            tbcp_pkg::M_X1Y1 | tbcp_pkg::M_X2Y2: begin
                if (ov_left + ov_top < ov_right + ov_bottom) begin
                    rx = ov_left;
                    ry = -ov_top;
                end else begin
                    rx = -ov_right;
                    ry = ov_bottom;
                end
            end
            default: ;
        endcase

        res.push_x = clip16(rx);
        res.push_y = clip16(ry);
        res.mask   = mask;
        return res;
    endfunction

    // Follow both channels and the register port at every rising edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_cfg  = 7'd64;
            height_cfg = 7'd64;
            pushes_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    tbcp_pkg::CFG_MAP_WIDTH:  width_cfg  = i_cfg_data;
                    tbcp_pkg::CFG_MAP_HEIGHT: height_cfg = i_cfg_data;
                    default: ;
                endcase
            end

            // Compare each delivered result with the oldest prediction.
            if (i_out_valid && !i_out_stall) begin
                seen_push = '{i_push_x, i_push_y, i_blocked_mask};
                if (pushes_due.size() == 0) begin
                    fail_count++;
                    $display("%0t: result with nothing expected: push_x %0d push_y %0d mask %b",
                             $time, seen_push.push_x, seen_push.push_y, seen_push.mask);
                end else begin
                    due_push = pushes_due.pop_front();
                    if (seen_push.push_x !== due_push.push_x) begin
                        fail_count++;
                        $display("%0t: push_x expected %0d, got %0d",
                                 $time, due_push.push_x, seen_push.push_x);
                    end
                    if (seen_push.push_y !== due_push.push_y) begin
                        fail_count++;
                        $display("%0t: push_y expected %0d, got %0d",
                                 $time, due_push.push_y, seen_push.push_y);
                    end
                    if (seen_push.mask !== due_push.mask) begin
                        fail_count++;
                        $display("%0t: blocked_mask expected %b, got %b",
                                 $time, due_push.mask, seen_push.mask);
                    end
                end
            end

            // Apply each accepted request in order.
            if (i_in_valid && !i_in_stall) begin
                seen_req = {i_op, i_tile_col, i_tile_row, i_tile_code,
                            i_pos_x, i_pos_y, i_half_w, i_half_h};
                if (seen_req.op == tbcp_pkg::OP_WRITE) begin
                    tile_mem[int'(seen_req.tile_row)*MAX_COLS + int'(seen_req.tile_col)] =
                        seen_req.tile_code;
                end else begin
                    pushes_due.push_back(predict_push(seen_req));
                end
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= pushes_due.size();
    end

endmodule

>>> tb/sv/testbench.sv
// Top of the testbench for the tile box collision push block: clock, reset, stimulus
// and the verdict. Depends on tbcp_pkg, the block itself and tile_push_checker.
module testbench;

    localparam int MAX_COLS     = 64;
    localparam int MAX_ROWS     = 64;
    localparam int ONE_FX       = 256;
    localparam int HALF_FX      = 128;
    localparam int LIMIT_CYCLES = 400000;
    localparam int LONG_HOLD    = 80;
    localparam int SETTLE       = 8;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 154;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               in_valid     = 1'b0;
    logic               in_stall;
    tbcp_pkg::t_item    tile_req     = '0;
    logic               out_valid;
    logic               out_stall    = 1'b0;
    logic signed [15:0] push_x;
    logic signed [15:0] push_y;
    logic [3:0]         blocked_mask;
    logic               cfg_we       = 1'b0;
    logic [0:0]         cfg_idx      = tbcp_pkg::CFG_MAP_WIDTH;
    logic [6:0]         cfg_data     = 7'd0;
    int                 fail_count;
    int                 pending;

    // Map sizes per phase: the extremes zero, one, full and oversized among them.
    int plan_cols [PHASES] = '{64, 1, 0, 127, 64, 9, 20, 64};
    int plan_rows [PHASES] = '{64, 1, 40, 127, 1, 64, 13, 64};

    // Stimulus bookkeeping: cells written so far and the map size in effect.
    bit tile_written [MAX_COLS*MAX_ROWS];
    int cols_in_use  = 64;
    int rows_in_use  = 64;
    int write_count  = 0;
    int query_count  = 0;
    int holds_asked  = 0;
    int holds_done   = 0;
    int cycle_count  = 0;
    int phase_end    = 0;
    bit paused       = 1'b0;
    bit quiet        = 1'b0;
    bit calm         = 1'b0;

    tile_box_collision_push uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_op           (tile_req.op),
        .i_tile_col     (tile_req.tile_col),
        .i_tile_row     (tile_req.tile_row),
        .i_tile_code    (tile_req.tile_code),
        .i_pos_x        (tile_req.pos_x),
        .i_pos_y        (tile_req.pos_y),
        .i_half_w       (tile_req.half_w),
        .i_half_h       (tile_req.half_h),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_push_x       (push_x),
        .o_push_y       (push_y),
        .o_blocked_mask (blocked_mask),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data)
    );

    tile_push_checker u_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_op           (tile_req.op),
        .i_tile_col     (tile_req.tile_col),
        .i_tile_row     (tile_req.tile_row),
        .i_tile_code    (tile_req.tile_code),
        .i_pos_x        (tile_req.pos_x),
        .i_pos_y        (tile_req.pos_y),
        .i_half_w       (tile_req.half_w),
        .i_half_h       (tile_req.half_h),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_push_x       (push_x),
        .i_push_y       (push_y),
        .i_blocked_mask (blocked_mask),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Guard against a hung run.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result side: random stall bursts, plus one long hold when the sender asks for it.
    initial begin
        forever begin
            @(posedge clk);
            if (holds_done < holds_asked) begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                out_stall <= 1'b0;
                holds_done++;
            end else if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Same cell rounding as the block, needed to know which tiles a query reads.
    function automatic int nearest_cell(input int p);
        int v;
        v = p - HALF_FX;
        if (v >= 0) begin
            return (v + HALF_FX) >>> 8;
        end
        return -((-v + HALF_FX) >>> 8);
    endfunction

    // Tile codes come mostly from a small set so that queries hit them often.
    function automatic logic [7:0] pick_code();
        if ($urandom_range(0, 4) != 0) begin
            return 8'($urandom_range(0, 3));
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic signed [15:0] pick_pos(input int cells);
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 7) begin
            return 16'(int'($urandom_range(0, (cells + 3)*ONE_FX)) - 2*ONE_FX);
        end else if (sel < 8) begin
            // Exactly on a cell centre or a cell edge.
            return 16'((int'($urandom_range(0, cells + 2)) - 1)*ONE_FX
                       + HALF_FX*int'($urandom_range(0, 1)));
        end
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic logic [11:0] pick_half();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 7) begin
            return 12'($urandom_range(0, 384));
        end else if (sel < 9) begin
            return 12'($urandom_range(0, 4095));
        end
        return ($urandom_range(0, 1) != 0) ? 12'hFFF : 12'h000;
    endfunction

    // Offer one request, with an optional gap before it, and wait until it is taken.
    task automatic put_request(input tbcp_pkg::t_item req);
        if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        tile_req <= req;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (req.op == tbcp_pkg::OP_WRITE) begin
            tile_written[int'(req.tile_row)*MAX_COLS + int'(req.tile_col)] = 1'b1;
            write_count++;
        end else begin
            query_count++;
        end
    endtask

    task automatic write_tile(input int col, input int row, input logic [7:0] code);
        logic [95:0] noise;
        tbcp_pkg::t_item req;
        noise = {$urandom(), $urandom(), $urandom()};
        req = noise[$bits(tbcp_pkg::t_item)-1:0];
        req.op        = tbcp_pkg::OP_WRITE;
        req.tile_col  = 6'(col);
        req.tile_row  = 6'(row);
        req.tile_code = code;
        put_request(req);
    endtask

    // Every in-map corner a query reads gets written first if it never was.
    task automatic query_box(input logic signed [15:0] px, input logic signed [15:0] py,
                             input logic [11:0] hw, input logic [11:0] hh,
                             input logic [7:0] code);
        logic [95:0] noise;
        tbcp_pkg::t_item req;
        int x1, y1, cx, cy;
        x1 = nearest_cell(px);
        y1 = nearest_cell(py);
        for (int dy = 0; dy < 2; dy++) begin
            for (int dx = 0; dx < 2; dx++) begin
                cx = x1 + dx;
                cy = y1 + dy;
                if (cx >= 0 && cy >= 0 && cx < cols_in_use && cy < rows_in_use
                        && !tile_written[cy*MAX_COLS + cx]) begin
                    write_tile(cx, cy, pick_code());
                end
            end
        end
        noise = {$urandom(), $urandom(), $urandom()};
        req = noise[$bits(tbcp_pkg::t_item)-1:0];
        req.op        = tbcp_pkg::OP_QUERY;
        req.tile_code = code;
        req.pos_x     = px;
        req.pos_y     = py;
        req.half_w    = hw;
        req.half_h    = hh;
        put_request(req);
    endtask

    // Drop valid, wait for every result and let the last writes settle.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Both size registers are written back to back while the block is idle.
    task automatic set_map_size(input int cols, input int rows);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_idx  <= tbcp_pkg::CFG_MAP_WIDTH;
        cfg_data <= 7'(cols);
        @(posedge clk);
        cfg_idx  <= tbcp_pkg::CFG_MAP_HEIGHT;
        cfg_data <= 7'(rows);
        @(posedge clk);
        cfg_we   <= 1'b0;
        cols_in_use = (cols > MAX_COLS) ? MAX_COLS : cols;
        rows_in_use = (rows > MAX_ROWS) ? MAX_ROWS : rows;
    endtask

    task automatic random_item();
        int col, row;
        if ($urandom_range(0, 99) < 35) begin
            if (cols_in_use > 0 && rows_in_use > 0 && $urandom_range(0, 3) != 0) begin
                col = $urandom_range(0, cols_in_use - 1);
                row = $urandom_range(0, rows_in_use - 1);
            end else begin
                col = $urandom_range(0, MAX_COLS - 1);
                row = $urandom_range(0, MAX_ROWS - 1);
            end
            write_tile(col, row, pick_code());
        end else begin
            query_box(pick_pos(cols_in_use), pick_pos(rows_in_use),
                      pick_half(), pick_half(), pick_code());
        end
    endtask

    // Main stimulus sequence.
    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // One blocking corner with equal overlaps, then a three-corner pocket.
        write_tile(5, 5, 8'd7);
        write_tile(6, 5, 8'd1);
        write_tile(5, 6, 8'd1);
        write_tile(6, 6, 8'd1);
        query_box(16'sd1500, 16'sd1500, 12'd200, 12'd200, 8'd7);
        query_box(16'sd1408, 16'sd1408, 12'd100, 12'd100, 8'd1);
        // Diagonal pair with equal sums, then no blocking corner at all.
        write_tile(6, 6, 8'd9);
        query_box(16'sd1408, 16'sd1408, 12'd100, 12'd100, 8'd1);
        query_box(16'sd1408, 16'sd1408, 12'd100, 12'd100, 8'd3);
        // Origin on an exact half: three corners lie outside the map.
        write_tile(0, 0, 8'd2);
        query_box(16'sd0, 16'sd0, 12'd64, 12'd64, 8'd5);
        // Far corner where every corner blocks.
        write_tile(63, 63, 8'd0);
        query_box(16'sd16256, 16'sd16256, 12'd300, 12'd300, 8'd0);
        // Field extremes, far outside the map.
        query_box(16'sh8000, 16'sh7FFF, 12'hFFF, 12'hFFF, 8'hFF);
        query_box(16'sh7FFF, 16'sh8000, 12'h000, 12'h000, 8'h00);
        // Map edges on the right and at the top.
        write_tile(63, 0, 8'hFF);
        write_tile(63, 1, 8'd3);
        query_box(16'sd16306, 16'sd200, 12'd90, 12'd150, 8'hFF);
        write_tile(0, 63, 8'h80);
        write_tile(1, 63, 8'd4);
        query_box(16'sd130, 16'sd16266, 12'd500, 12'd40, 8'h80);

        for (int ph = 0; ph < PHASES; ph++) begin
            set_map_size(plan_cols[ph], plan_rows[ph]);
            calm  = (ph == 3);
            quiet = (ph == PHASES - 1);
            // Long output hold while requests keep coming, so the input stalls.
            if (ph == 3) begin
                holds_asked++;
            end
            // Each phase runs until its share of requests, corner fills included, is sent.
            phase_end = write_count + query_count + PHASE_ITEMS;
            paused    = 1'b0;
            while (write_count + query_count < phase_end) begin
                random_item();
                // Sender pause until every pending result is out.
                if (ph == 5 && !paused
                        && write_count + query_count >= phase_end - PHASE_ITEMS/2) begin
                    wait_idle();
                    paused = 1'b1;
                end
            end
        end

        wait_idle();
        $display("Ran %0d tile writes and %0d box queries over %0d map sizes,",
                 write_count, query_count, PHASES + 1);
        $display("with request gaps, output stall bursts and one long output hold.");
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
